@@ rtl/core/cst_pkg.sv @@
// shared types and constants for the character stream tokenizer
package cst_pkg;

	localparam int TEXT_CAPACITY_DEF = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_ASSIGN = 8'h3D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_F = 8'h66;

	typedef enum logic [3:0] {
		KIND_IDENT = 4'd0,
		KIND_INT = 4'd1,
		KIND_IF = 4'd2,
		KIND_NUMBER = 4'd3,
		KIND_ASSIGN = 4'd4,
		KIND_PLUS = 4'd5,
		KIND_MINUS = 4'd6,
		KIND_LBRACE = 4'd7,
		KIND_RBRACE = 4'd8,
		KIND_SEMI = 4'd9,
		KIND_UNKNOWN = 4'd10,
		KIND_EOF = 4'd11
	} kind_t;

	typedef enum logic [2:0] {
		CL_SPACE,
		CL_LETTER,
		CL_DIGIT,
		CL_SINGLE,
		CL_EOI
	} class_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER
	} mode_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FLUSH,
		BK_TAIL
	} back_state_t;

	typedef struct packed {
		class_t cls;
		kind_t kind;
		logic [7:0] ch;
	} op_t;

endpackage

@@ rtl/core/cst_front.sv @@
// front end: accepts input beats and classifies each byte
module cst_front (
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,     // in_char
	input  logic s_tuser,           // end_of_input
	input  logic q_full,
	output logic q_push,
	output cst_pkg::op_t q_data
);
	import cst_pkg::*;

	assign s_tready = !q_full;
	assign q_push = s_tvalid && !q_full;

	always_comb begin
		q_data.ch = s_tdata;
		case (s_tdata)
			CH_ASSIGN: q_data.kind = KIND_ASSIGN;
			CH_PLUS: q_data.kind = KIND_PLUS;
			CH_MINUS: q_data.kind = KIND_MINUS;
			CH_LBRACE: q_data.kind = KIND_LBRACE;
			CH_RBRACE: q_data.kind = KIND_RBRACE;
			CH_SEMI: q_data.kind = KIND_SEMI;
			default: q_data.kind = KIND_UNKNOWN;
		endcase
		if (s_tuser) begin
			q_data.cls = CL_EOI;
		end else if (s_tdata inside {8'h20, [8'h09:8'h0D]}) begin
			q_data.cls = CL_SPACE;
		end else if (s_tdata inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
			q_data.cls = CL_LETTER;
		end else if (s_tdata inside {[8'h30:8'h39]}) begin
			q_data.cls = CL_DIGIT;
		end else begin
			q_data.cls = CL_SINGLE;
		end
	end

endmodule

@@ rtl/core/cst_queue.sv @@
// short queue of classified bytes between front and back
module cst_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cst_pkg::op_t push_data,
	output logic full,
	input  logic pop,
	output logic avail,
	output cst_pkg::op_t pop_data
);
	import cst_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign avail = (cnt_q != '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/cst_back.sv @@
// back end: gathers token text and emits result beats
module cst_back #(
	parameter int TEXT_CAPACITY = cst_pkg::TEXT_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_avail,
	input  cst_pkg::op_t op,
	output logic op_pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,     // text_char
	output logic m_tlast,           // last_char
	output logic [4:0] m_tuser      // token_kind, last_result
);
	import cst_pkg::*;

	localparam int DEPTH = TEXT_CAPACITY - 1;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W = $clog2(TEXT_CAPACITY);

	back_state_t st_q, st_d;
	mode_t mode_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] rd_q;
	logic [7:0] store_q [DEPTH];
	logic mi_q, mf_q;

	kind_t flush_kind_q;
	logic tail_q;
	kind_t tail_kind_q;
	logic [7:0] tail_char_q;
	logic nxt_start_q;
	logic nxt_num_q;
	logic [7:0] nxt_char_q;

	logic out_valid_q;
	kind_t out_kind_q;
	logic [7:0] out_char_q;
	logic out_lc_q, out_lr_q;

	logic out_free, take, eoi, cont, need_flush, last;
	kind_t tok_kind;

	logic emit, e_lc, e_lr, do_start, start_num, do_append, clr;
	kind_t e_kind;
	logic [7:0] e_char, start_ch;

	assign out_free = !out_valid_q || m_tready;
	assign take = (st_q == BK_IDLE) && op_avail && out_free;
	assign op_pop = take;
	assign eoi = (op.cls == CL_EOI);
	assign cont = ((mode_q == MODE_IDENT) && (op.cls == CL_LETTER || op.cls == CL_DIGIT))
		|| ((mode_q == MODE_NUMBER) && (op.cls == CL_DIGIT));
	assign need_flush = !cont && (mode_q != MODE_IDLE);
	assign last = (rd_q == len_q - LEN_W'(1));

	always_comb begin
		if (mode_q == MODE_NUMBER) begin
			tok_kind = KIND_NUMBER;
		end else if (mi_q && len_q == LEN_W'(3)) begin
			tok_kind = KIND_INT;
		end else if (mf_q && len_q == LEN_W'(2)) begin
			tok_kind = KIND_IF;
		end else begin
			tok_kind = KIND_IDENT;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: begin
				if (take && need_flush) begin
					st_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (out_free && last) begin
					st_d = tail_q ? BK_TAIL : BK_IDLE;
				end
			end
			BK_TAIL: begin
				if (out_free) begin
					st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		e_kind = KIND_EOF;
		e_char = 8'h00;
		e_lc = 1'b0;
		e_lr = 1'b0;
		do_start = 1'b0;
		start_num = 1'b0;
		start_ch = op.ch;
		do_append = 1'b0;
		clr = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (take) begin
					if (cont) begin
						do_append = 1'b1;
					end else if (!need_flush) begin
						if (op.cls == CL_EOI || op.cls == CL_SINGLE) begin
							emit = 1'b1;
							e_kind = eoi ? KIND_EOF : op.kind;
							e_char = eoi ? 8'h00 : op.ch;
							e_lc = 1'b1;
							e_lr = 1'b1;
						end else if (op.cls == CL_LETTER || op.cls == CL_DIGIT) begin
							do_start = 1'b1;
							start_num = (op.cls == CL_DIGIT);
						end
					end
				end
			end
			BK_FLUSH: begin
				if (out_free) begin
					emit = 1'b1;
					e_kind = flush_kind_q;
					e_char = store_q[rd_q[IDX_W-1:0]];
					e_lc = last;
					e_lr = last && !tail_q;
					if (last) begin
						clr = 1'b1;
						do_start = nxt_start_q;
						start_num = nxt_num_q;
						start_ch = nxt_char_q;
					end
				end
			end
			BK_TAIL: begin
				if (out_free) begin
					emit = 1'b1;
					e_kind = tail_kind_q;
					e_char = tail_char_q;
					e_lc = 1'b1;
					e_lr = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			mode_q <= MODE_IDLE;
			len_q <= '0;
			rd_q <= '0;
			mi_q <= 1'b0;
			mf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (take && need_flush) begin
				rd_q <= '0;
			end else if (st_q == BK_FLUSH && emit) begin
				rd_q <= rd_q + LEN_W'(1);
			end
			if (clr) begin
				mode_q <= MODE_IDLE;
				len_q <= '0;
			end
			if (do_start) begin
				mode_q <= start_num ? MODE_NUMBER : MODE_IDENT;
				len_q <= LEN_W'(1);
				mi_q <= (start_ch == CH_I);
				mf_q <= (start_ch == CH_I);
			end else if (do_append && len_q < LEN_W'(DEPTH)) begin
				len_q <= len_q + LEN_W'(1);
				if (len_q == LEN_W'(1)) begin
					mi_q <= mi_q && (op.ch == CH_N);
					mf_q <= mf_q && (op.ch == CH_F);
				end else if (len_q == LEN_W'(2)) begin
					mi_q <= mi_q && (op.ch == CH_T);
					mf_q <= 1'b0;
				end else begin
					mi_q <= 1'b0;
					mf_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			store_q[0] <= start_ch;
		end else if (do_append && len_q < LEN_W'(DEPTH)) begin
			store_q[len_q[IDX_W-1:0]] <= op.ch;
		end
		if (take && need_flush) begin
			flush_kind_q <= tok_kind;
			tail_q <= (op.cls == CL_EOI || op.cls == CL_SINGLE);
			tail_kind_q <= eoi ? KIND_EOF : op.kind;
			tail_char_q <= eoi ? 8'h00 : op.ch;
			nxt_start_q <= (op.cls == CL_LETTER || op.cls == CL_DIGIT);
			nxt_num_q <= (op.cls == CL_DIGIT);
			nxt_char_q <= op.ch;
		end
		if (emit) begin
			out_kind_q <= e_kind;
			out_char_q <= e_char;
			out_lc_q <= e_lc;
			out_lr_q <= e_lr;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_char_q;
	assign m_tlast = out_lc_q;
	assign m_tuser = {out_lr_q, out_kind_q};

endmodule

@@ rtl/core/char_stream_tokenizer.sv @@
// top level of the character stream tokenizer
// input beats carry one source byte on s_tdata, or an end-of-input mark on s_tuser.
// output beats carry one character of token text on m_tdata and its kind on m_tuser[3:0];
// m_tlast marks the final character of a token, m_tuser[4] the final beat caused
// by one input beat. an identifier or number is emitted once the byte after it
// arrives; that byte is then handled itself (single-character, unknown or eof
// token, or the start of a new token). bytes past the text store are dropped.
// with the queue empty and the back end idle, a beat that gives a token directly
// passes through the queue register and the output register before it shows on
// m_tvalid. a byte that ends a token has the back end flush the stored characters
// first, then emit the byte's own token if it gives one; no new byte is taken until
// it is done. the back end emits one beat per cycle from the text store while m_tready is high.
// a four-entry queue sits between classification and emission, so s_tready
// stays high while the back end flushes until the queue fills.
// reset clears the queue, returns the scanner to idle and empties the output
// register. when the receiver stalls, the output beat holds and the back end waits.
module char_stream_tokenizer #(
	parameter int TEXT_CAPACITY = cst_pkg::TEXT_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,     // in_char
	input  logic s_tuser,           // end_of_input
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,     // text_char
	output logic m_tlast,           // last_char
	output logic [4:0] m_tuser      // token_kind[3:0], last_result[4]
);
	import cst_pkg::*;

	logic q_full, q_push, q_avail, q_pop;
	op_t q_in, q_out;

	cst_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_in)
	);

	cst_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_in),
		.full(q_full),
		.pop(q_pop),
		.avail(q_avail),
		.pop_data(q_out)
	);

	cst_back #(
		.TEXT_CAPACITY(TEXT_CAPACITY)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_avail(q_avail),
		.op(q_out),
		.op_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	a_eof_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3:0] == KIND_EOF) |-> (m_tlast && m_tuser[4] && m_tdata == 8'h00))
		else $error("eof beat not closing");

	a_result_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[4]) |-> m_tlast)
		else $error("final result inside a token");

	a_int_text: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3:0] == KIND_INT) |->
		(m_tdata == CH_I || m_tdata == CH_N || m_tdata == CH_T))
		else $error("int keyword with wrong text");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_avail)
		else $error("queue popped while empty");

endmodule

@@ tb/char_stream_tokenizer_tb.sv @@
// testbench for the character stream tokenizer: directed, long-token and random source streams
module char_stream_tokenizer_tb;
	import cst_pkg::*;

	localparam int STORE_DEPTH = TEXT_CAPACITY_DEF - 1;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BEATS = 400;
	localparam int TOTAL_BEATS = 480;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		kind_t kind;
		logic [7:0] ch;
		bit last_char;
		bit last_result;
	} token_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic [4:0] m_tuser;

	bit quiet = 1'b0;

	mode_t scan_state = MODE_IDLE;
	logic [7:0] token_text [STORE_DEPTH];
	int token_len = 0;
	token_beat_t pending_beats [$];
	token_beat_t checked_beat;

	int beats_sent = 0;
	int eoi_sent = 0;
	int beats_checked = 0;
	int dropped_chars = 0;
	int mismatches = 0;
	int idle_cycles;

	string kw_pool [8] = '{"int", "if", "in", "i", "ifz", "int0", "If", "inta"};
	logic [7:0] singles [6] = '{CH_ASSIGN, CH_PLUS, CH_MINUS, CH_LBRACE, CH_RBRACE, CH_SEMI};
	logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	char_stream_tokenizer #(
		.TEXT_CAPACITY(TEXT_CAPACITY_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic kind_t single_kind(logic [7:0] c);
		case (c)
			CH_ASSIGN: return KIND_ASSIGN;
			CH_PLUS: return KIND_PLUS;
			CH_MINUS: return KIND_MINUS;
			CH_LBRACE: return KIND_LBRACE;
			CH_RBRACE: return KIND_RBRACE;
			CH_SEMI: return KIND_SEMI;
			default: return KIND_UNKNOWN;
		endcase
	endfunction

	function automatic void queue_beat(kind_t kind, logic [7:0] ch, bit last);
		token_beat_t b;
		b.kind = kind;
		b.ch = ch;
		b.last_char = last;
		b.last_result = 1'b0;
		pending_beats.push_back(b);
	endfunction

	function automatic void store_char(logic [7:0] c);
		if (token_len < STORE_DEPTH) begin
			token_text[token_len] = c;
			token_len++;
		end else begin
			dropped_chars++;
		end
	endfunction

	function automatic void flush_token();
		kind_t kind;
		if (scan_state == MODE_NUMBER) begin
			kind = KIND_NUMBER;
		end else if (token_len == 3 && token_text[0] == CH_I && token_text[1] == CH_N &&
				token_text[2] == CH_T) begin
			kind = KIND_INT;
		end else if (token_len == 2 && token_text[0] == CH_I && token_text[1] == CH_F) begin
			kind = KIND_IF;
		end else begin
			kind = KIND_IDENT;
		end
		for (int i = 0; i < token_len; i++)
			queue_beat(kind, token_text[i], i == token_len - 1);
		scan_state = MODE_IDLE;
		token_len = 0;
	endfunction

	// expected output beats for one accepted source beat
	function automatic void lex_byte(logic [7:0] c, bit eoi);
		int first_idx;
		first_idx = pending_beats.size();
		if (eoi) begin
			if (scan_state != MODE_IDLE)
				flush_token();
			queue_beat(KIND_EOF, 8'h00, 1'b1);
		end else if (scan_state == MODE_IDENT && (is_alpha(c) || is_num(c))) begin
			store_char(c);
		end else if (scan_state == MODE_NUMBER && is_num(c)) begin
			store_char(c);
		end else begin
			if (scan_state != MODE_IDLE)
				flush_token();
			if (!is_blank(c)) begin
				if (is_alpha(c)) begin
					scan_state = MODE_IDENT;
					token_len = 0;
					store_char(c);
				end else if (is_num(c)) begin
					scan_state = MODE_NUMBER;
					token_len = 0;
					store_char(c);
				end else begin
					queue_beat(single_kind(c), c, 1'b1);
				end
			end
		end
		if (pending_beats.size() > first_idx)
			pending_beats[pending_beats.size() - 1].last_result = 1'b1;
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'($urandom_range(1) ? 8'h61 + $urandom_range(25) : 8'h41 + $urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(8'h30 + $urandom_range(9));
	endfunction

	task automatic send_beat(input logic [7:0] c, input bit eoi);
		while (!quiet && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom_range(255));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= eoi;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		lex_byte(c, eoi);
		beats_sent++;
		if (eoi)
			eoi_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	task automatic send_word(input bit numeric, input int len);
		send_beat(numeric ? rand_digit() : rand_letter(), 1'b0);
		for (int i = 1; i < len; i++)
			send_beat((numeric || $urandom_range(2) == 0) ? rand_digit() : rand_letter(), 1'b0);
	endtask

	task automatic send_random_token();
		int len;
		len = ($urandom_range(11) == 0) ? $urandom_range(25, 45) : $urandom_range(1, 6);
		case ($urandom_range(11))
			0, 1, 2: send_word(1'b0, len);
			3: send_text(kw_pool[3'($urandom_range(7))]);
			4: send_word(1'b1, len);
			5, 6: send_beat(singles[3'($urandom_range(5))], 1'b0);
			7, 8: begin
				for (int i = 0; i < $urandom_range(1, 3); i++)
					send_beat(blanks[3'($urandom_range(5))], 1'b0);
			end
			9: send_beat(8'($urandom_range(255)), 1'b0);
			10: send_beat(8'($urandom_range(128, 255)), 1'b0);
			default: send_beat(8'($urandom_range(255)), 1'b1);
		endcase
	endtask

	task automatic test_directed();
		send_text("int");
		send_beat(8'h20, 1'b0);
		send_text("if");
		send_beat(8'h09, 1'b0);
		send_text("x9=07;{}+-");
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h0A, 1'b0);
		send_beat(8'h0B, 1'b0);
		send_beat(8'h0C, 1'b0);
		send_beat(8'h0D, 1'b0);
		send_beat(8'hA5, 1'b1);
		send_beat(8'h5A, 1'b1);
	endtask

	// tokens at and past the text store size, ended by a space, a letter and end of input
	task automatic test_long_tokens();
		send_word(1'b0, STORE_DEPTH);
		send_beat(8'h20, 1'b0);
		send_word(1'b1, STORE_DEPTH + 1);
		send_text("x");
		send_beat(8'h00, 1'b1);
		send_word(1'b0, STORE_DEPTH + 9);
		send_beat(8'hFF, 1'b1);
	endtask

	task automatic test_random_source();
		while (beats_sent < RANDOM_BEATS)
			send_random_token();
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		while (beats_sent < TOTAL_BEATS)
			send_random_token();
		send_beat(8'h00, 1'b1);
		quiet = 1'b0;
	endtask

	always @(posedge clk)
		m_tready <= quiet || ($urandom_range(99) >= 8);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: kind %0d char %02h last_char %0b last_result %0b",
						m_tuser[3:0], m_tdata, m_tlast, m_tuser[4]);
			end else begin
				checked_beat = pending_beats.pop_front();
				beats_checked++;
				if (m_tuser[3:0] !== checked_beat.kind || m_tdata !== checked_beat.ch ||
						m_tlast !== checked_beat.last_char ||
						m_tuser[4] !== checked_beat.last_result) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("beat %0d: expected kind %0d char %02h last %0b/%0b",
							beats_checked, checked_beat.kind, checked_beat.ch,
							checked_beat.last_char, checked_beat.last_result);
						$display("  got kind %0d char %02h last %0b/%0b",
							m_tuser[3:0], m_tdata, m_tlast, m_tuser[4]);
					end
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no beat moved for %0d cycles, %0d beats outstanding",
			IDLE_LIMIT, pending_beats.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_tokens();
		test_random_source();
		test_back_to_back();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d source beats (%0d end-of-input marks), checked %0d token beats",
			beats_sent, eoi_sent, beats_checked);
		$display("%0d characters dropped past the text store, %0d mismatches",
			dropped_chars, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/cst_pkg.sv
rtl/core/cst_front.sv
rtl/core/cst_queue.sv
rtl/core/cst_back.sv
rtl/core/char_stream_tokenizer.sv
tb/char_stream_tokenizer_tb.sv
